// ===== rtl/tlv_stream_parser_core_defines.svh =====
// ---------------------------------------------------------------------------
// TLV stream parser assertion macros
// Concurrent assertion helpers, clocked on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef TLV_STREAM_PARSER_CORE_DEFINES_SVH
`define TLV_STREAM_PARSER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define TLVSP_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define TLVSP_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TLVSP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TLVSP_ASSERT_ALWAYS(lbl, expr)
`define TLVSP_ASSERT_IMPLY(lbl, ante, cons)
`define TLVSP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/tlvsp_pkg.sv =====
// ---------------------------------------------------------------------------
// TLV stream parser package
// Constants, event and status codes and the result type of the parser.
// ---------------------------------------------------------------------------
`default_nettype none

package tlvsp_pkg;

    localparam int POSITION_BITS = 20;
    localparam int LENGTH_BITS   = 20;
    localparam int CMP_BITS      = ((POSITION_BITS > LENGTH_BITS) ?
                                    POSITION_BITS : LENGTH_BITS) + 2;

    localparam int HDR_LEN     = 5;
    localparam int REC_HDR_LEN = 3;
    localparam int MAGIC_LEN   = 4;

    localparam logic [7:0] VERSION_BYTE = 8'h01;

    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    localparam logic [1:0] EV_HEADER  = 2'd0;
    localparam logic [1:0] EV_PAYLOAD = 2'd1;
    localparam logic [1:0] EV_FINISH  = 2'd2;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_TOO_SMALL   = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC   = 3'd2;
    localparam logic [2:0] ST_BAD_VERSION = 3'd3;
    localparam logic [2:0] ST_TRUNC_HDR   = 3'd4;
    localparam logic [2:0] ST_OVERRUN     = 3'd5;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [7:0]  record_type;
        logic [15:0] record_length;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [2:0]  status;
        logic        last_of_run;
    } result_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] value;
        case (idx)
            2'd0:    value = 8'h54;
            2'd1:    value = 8'h4C;
            2'd2:    value = 8'h56;
            2'd3:    value = 8'h31;
            default: value = 8'h00;
        endcase
        return value;
    endfunction

    function automatic result_t finish_result(input logic [2:0] st);
        result_t r;
        r           = '0;
        r.event_res = EV_FINISH;
        r.status    = st;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tlv_stream_parser_core.sv =====
// ---------------------------------------------------------------------------
// TLV stream parser core
// Parses a type-length-value buffer one byte per clock while in_stall is low
// and emits record header, payload and finish events.
// ---------------------------------------------------------------------------
// The input channel carries one buffer byte per request, with the buffer's
// length and a start flag on its first byte. The output channel carries one
// event per request: a record header, a payload byte, or a finish event with
// its status. A byte gives zero, one or two events; the last one it gives is
// marked by last_of_run.
// Every byte is parsed in the cycle it is accepted; its events are written to
// a four-entry registered output queue whose head drives the output. A byte
// can be accepted every cycle while in_stall is low; events leave at one per
// cycle while out_stall is low, which sets the sustained rate where bytes give
// two events. in_stall is high while fewer than two queue entries are free,
// so a stalled receiver holds the input back; nothing is lost.
// Reset empties the queue and leaves the parser idle until a byte with
// start_req arrives. Bytes without start_req while idle give no events.
// ---------------------------------------------------------------------------
`default_nettype none

`include "tlv_stream_parser_core_defines.svh"

module tlv_stream_parser_core
    import tlvsp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [7:0]             data_byte,
    input  wire logic [LENGTH_BITS-1:0] buffer_length,
    input  wire logic                   start_req,

    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [1:0]                  event_res,
    output logic [7:0]                  record_type,
    output logic [15:0]                 record_length,
    output logic [7:0]                  payload_byte,
    output logic [15:0]                 payload_index,
    output logic [2:0]                  status,
    output logic                        last_of_run
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_TYPE,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD
    } phase_t;

    phase_t                   phase_reg, phase_next, eff_phase;
    logic [POSITION_BITS-1:0] byte_position_reg, byte_position_next, eff_pos;
    logic [7:0]               current_type_reg, current_type_next;
    logic [7:0]               length_high_reg, length_high_next;
    logic [15:0]              current_length_reg, current_length_next;
    logic [15:0]              payload_count_reg, payload_count_next;
    logic [LENGTH_BITS-1:0]   total_length_reg, total_length_next, eff_total;
    logic                     halted_reg, halted_next, eff_halted;

    logic [CMP_BITS-1:0]      pos_ext, pos_plus1, total_ext, overrun_end;
    logic [15:0]              new_length, count_inc;

    result_t                  res0, res1;
    logic [1:0]               push_count;
    logic                     finish_pushed;

    result_t                  fifo_mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [FIFO_PTR_BITS-1:0] wr_ptr_second;
    logic [FIFO_CNT_BITS-1:0] fifo_count_reg, fifo_count_next;
    logic                     in_accept, out_accept;
    result_t                  head;

    assign in_stall   = fifo_count_reg > FIFO_CNT_BITS'(FIFO_DEPTH - 2);
    assign in_accept  = in_valid && !in_stall;
    assign out_valid  = fifo_count_reg != '0;
    assign out_accept = out_valid && !out_stall;

    assign eff_phase  = start_req ? PH_HEADER : phase_reg;
    assign eff_pos    = start_req ? '0 : byte_position_reg;
    assign eff_total  = start_req ? buffer_length : total_length_reg;
    assign eff_halted = start_req ? 1'b0 : halted_reg;

    assign pos_ext     = CMP_BITS'(eff_pos);
    assign pos_plus1   = pos_ext + CMP_BITS'(1);
    assign total_ext   = CMP_BITS'(eff_total);
    assign new_length  = {length_high_reg, data_byte};
    assign overrun_end = pos_plus1 + CMP_BITS'(new_length);
    assign count_inc   = payload_count_reg + 16'd1;

    always_comb
    begin
        phase_next          = phase_reg;
        byte_position_next  = byte_position_reg;
        current_type_next   = current_type_reg;
        length_high_next    = length_high_reg;
        current_length_next = current_length_reg;
        payload_count_next  = payload_count_reg;
        total_length_next   = total_length_reg;
        halted_next         = halted_reg;
        res0                = '0;
        res1                = '0;
        push_count          = 2'd0;

        if (in_accept)
        begin
            if (start_req)
            begin
                phase_next          = PH_HEADER;
                byte_position_next  = '0;
                current_type_next   = '0;
                length_high_next    = '0;
                current_length_next = '0;
                payload_count_next  = '0;
                total_length_next   = buffer_length;
                halted_next         = 1'b0;
            end

            if (start_req && (buffer_length < LENGTH_BITS'(HDR_LEN)))
            begin
                res0        = finish_result(ST_TOO_SMALL);
                push_count  = 2'd1;
                halted_next = 1'b1;
            end
            else if (!eff_halted)
            begin
                byte_position_next = eff_pos + POSITION_BITS'(1);
                case (eff_phase)
                    PH_HEADER:
                    begin
                        if (pos_ext < CMP_BITS'(MAGIC_LEN))
                        begin
                            if (data_byte != magic_byte(eff_pos[1:0]))
                            begin
                                res0        = finish_result(ST_BAD_MAGIC);
                                push_count  = 2'd1;
                                halted_next = 1'b1;
                            end
                        end
                        else if (data_byte != VERSION_BYTE)
                        begin
                            res0        = finish_result(ST_BAD_VERSION);
                            push_count  = 2'd1;
                            halted_next = 1'b1;
                        end
                        else if (pos_plus1 >= total_ext)
                        begin
                            res0        = finish_result(ST_OK);
                            push_count  = 2'd1;
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_TYPE;
                        end
                    end
                    PH_TYPE:
                    begin
                        if ((pos_ext + CMP_BITS'(REC_HDR_LEN)) > total_ext)
                        begin
                            res0        = finish_result(ST_TRUNC_HDR);
                            push_count  = 2'd1;
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            current_type_next = data_byte;
                            phase_next        = PH_LEN_HI;
                        end
                    end
                    PH_LEN_HI:
                    begin
                        length_high_next = data_byte;
                        phase_next       = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        current_length_next = new_length;
                        if (overrun_end > total_ext)
                        begin
                            res0        = finish_result(ST_OVERRUN);
                            push_count  = 2'd1;
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            res0.event_res     = EV_HEADER;
                            res0.record_type   = current_type_reg;
                            res0.record_length = new_length;
                            push_count         = 2'd1;
                            payload_count_next = '0;
                            if (new_length != 16'd0)
                            begin
                                phase_next = PH_PAYLOAD;
                            end
                            else if (pos_plus1 >= total_ext)
                            begin
                                res1        = finish_result(ST_OK);
                                push_count  = 2'd2;
                                halted_next = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_TYPE;
                            end
                        end
                    end
                    default:
                    begin
                        res0.event_res     = EV_PAYLOAD;
                        res0.record_type   = current_type_reg;
                        res0.record_length = current_length_reg;
                        res0.payload_byte  = data_byte;
                        res0.payload_index = payload_count_reg;
                        push_count         = 2'd1;
                        payload_count_next = count_inc;
                        if (count_inc >= current_length_reg)
                        begin
                            if (pos_plus1 >= total_ext)
                            begin
                                res1        = finish_result(ST_OK);
                                push_count  = 2'd2;
                                halted_next = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_TYPE;
                            end
                        end
                    end
                endcase
            end
        end

        if (push_count == 2'd1)
        begin
            res0.last_of_run = 1'b1;
        end
        if (push_count == 2'd2)
        begin
            res1.last_of_run = 1'b1;
        end
    end

    assign finish_pushed = ((push_count == 2'd1) && (res0.event_res == EV_FINISH)) ||
                           ((push_count == 2'd2) && (res1.event_res == EV_FINISH));

    assign wr_ptr_second   = wr_ptr_reg + FIFO_PTR_BITS'(1);
    assign wr_ptr_next     = wr_ptr_reg + FIFO_PTR_BITS'(push_count);
    assign rd_ptr_next     = rd_ptr_reg + FIFO_PTR_BITS'(out_accept);
    assign fifo_count_next = fifo_count_reg + FIFO_CNT_BITS'(push_count)
                             - FIFO_CNT_BITS'(out_accept);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_HEADER;
            byte_position_reg  <= '0;
            current_type_reg   <= '0;
            length_high_reg    <= '0;
            current_length_reg <= '0;
            payload_count_reg  <= '0;
            total_length_reg   <= '0;
            halted_reg         <= 1'b1;
            wr_ptr_reg         <= '0;
            rd_ptr_reg         <= '0;
            fifo_count_reg     <= '0;
        end
        else
        begin
            phase_reg          <= phase_next;
            byte_position_reg  <= byte_position_next;
            current_type_reg   <= current_type_next;
            length_high_reg    <= length_high_next;
            current_length_reg <= current_length_next;
            payload_count_reg  <= payload_count_next;
            total_length_reg   <= total_length_next;
            halted_reg         <= halted_next;
            wr_ptr_reg         <= wr_ptr_next;
            rd_ptr_reg         <= rd_ptr_next;
            fifo_count_reg     <= fifo_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            fifo_mem_reg[wr_ptr_reg] <= res0;
        end
        if (push_count == 2'd2)
        begin
            fifo_mem_reg[wr_ptr_second] <= res1;
        end
    end

    assign head          = fifo_mem_reg[rd_ptr_reg];
    assign event_res     = head.event_res;
    assign record_type   = head.record_type;
    assign record_length = head.record_length;
    assign payload_byte  = head.payload_byte;
    assign payload_index = head.payload_index;
    assign status        = head.status;
    assign last_of_run   = head.last_of_run;

    `TLVSP_ASSERT_ALWAYS(a_fifo_bound, fifo_count_reg <= FIFO_CNT_BITS'(FIFO_DEPTH))
    `TLVSP_ASSERT_IMPLY(a_idle_silent, in_accept && !start_req && halted_reg, push_count == 2'd0)
    `TLVSP_ASSERT_NEXT(a_finish_halts, finish_pushed, halted_reg)

endmodule

`default_nettype wire

// ===== test/tb_tlv_stream_parser_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// TLV stream parser core testbench
// Feeds a table of directed bytes, then random well-formed and damaged
// buffers, with random idle cycles on both channels, and checks every event
// against the table or a behavioural parser kept inside the testbench.
// ---------------------------------------------------------------------------
module tb_tlv_stream_parser_core;
    import tlvsp_pkg::*;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          RANDOM_ITEMS = 1950;
    localparam int          TAIL_CYCLES  = 20;
    localparam int          NUM_ROWS     = 29;
    localparam logic [31:0] MAGIC_WORD   = 32'h544C5631;

    typedef enum logic [2:0] {
        SEEK_HEADER,
        SEEK_TYPE,
        SEEK_LEN_HI,
        SEEK_LEN_LO,
        SEEK_PAYLOAD
    } parse_phase_t;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_SILENT,
        ROW_FINISH
    } row_check_t;

    typedef struct packed {
        logic [7:0]             data;
        logic [LENGTH_BITS-1:0] blen;
        logic                   start;
        row_check_t             check;
        logic [2:0]             status;
    } stim_row_t;

    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        {8'hFF, 20'hFFFFF, 1'b0, ROW_SILENT,  ST_OK},
        {8'h00, 20'h00001, 1'b1, ROW_FINISH,  ST_TOO_SMALL},
        {8'h00, 20'h00005, 1'b1, ROW_FINISH,  ST_BAD_MAGIC},
        {8'h54, 20'h00009, 1'b1, ROW_PREDICT, ST_OK},
        {8'h4C, 20'h00009, 1'b0, ROW_PREDICT, ST_OK},
        {8'h54, 20'h00005, 1'b1, ROW_PREDICT, ST_OK},
        {8'h4C, 20'hFFFFF, 1'b0, ROW_PREDICT, ST_OK},
        {8'h56, 20'h00001, 1'b0, ROW_PREDICT, ST_OK},
        {8'h31, 20'h00002, 1'b0, ROW_PREDICT, ST_OK},
        {8'h01, 20'h00003, 1'b0, ROW_FINISH,  ST_OK},
        {8'h54, 20'hFFFFF, 1'b1, ROW_PREDICT, ST_OK},
        {8'h4C, 20'h00001, 1'b0, ROW_PREDICT, ST_OK},
        {8'h56, 20'hAAAAA, 1'b0, ROW_PREDICT, ST_OK},
        {8'h31, 20'h55555, 1'b0, ROW_PREDICT, ST_OK},
        {8'hFF, 20'hFFFFF, 1'b0, ROW_FINISH,  ST_BAD_VERSION},
        {8'h54, 20'h00007, 1'b1, ROW_PREDICT, ST_OK},
        {8'h4C, 20'h00007, 1'b0, ROW_PREDICT, ST_OK},
        {8'h56, 20'h00007, 1'b0, ROW_PREDICT, ST_OK},
        {8'h31, 20'h00007, 1'b0, ROW_PREDICT, ST_OK},
        {8'h01, 20'h00007, 1'b0, ROW_PREDICT, ST_OK},
        {8'h00, 20'h00007, 1'b0, ROW_FINISH,  ST_TRUNC_HDR},
        {8'h54, 20'h00009, 1'b1, ROW_PREDICT, ST_OK},
        {8'h4C, 20'h00009, 1'b0, ROW_PREDICT, ST_OK},
        {8'h56, 20'h00009, 1'b0, ROW_PREDICT, ST_OK},
        {8'h31, 20'h00009, 1'b0, ROW_PREDICT, ST_OK},
        {8'h01, 20'h00009, 1'b0, ROW_PREDICT, ST_OK},
        {8'hFF, 20'h00009, 1'b0, ROW_PREDICT, ST_OK},
        {8'hFF, 20'h00009, 1'b0, ROW_PREDICT, ST_OK},
        {8'hFF, 20'h00009, 1'b0, ROW_FINISH,  ST_OVERRUN}
    };

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   in_valid      = 1'b0;
    logic                   in_stall;
    logic [7:0]             data_byte     = 8'h00;
    logic [LENGTH_BITS-1:0] buffer_length = 20'h00001;
    logic                   start_req     = 1'b0;
    logic                   out_valid;
    logic                   out_stall     = 1'b0;
    logic [1:0]             event_res;
    logic [7:0]             record_type;
    logic [15:0]            record_length;
    logic [7:0]             payload_byte;
    logic [15:0]            payload_index;
    logic [2:0]             status;
    logic                   last_of_run;

    logic [POSITION_BITS-1:0] byte_pos  = '0;
    parse_phase_t             phase     = SEEK_HEADER;
    logic [7:0]               rec_type  = '0;
    logic [7:0]               len_hi    = '0;
    logic [15:0]              rec_len   = '0;
    logic [15:0]              pay_count = '0;
    logic [LENGTH_BITS-1:0]   buf_len   = '0;
    logic                     halted    = 1'b1;

    result_t                byte_events [$];
    result_t                pending_events [$];
    result_t                head_event;
    logic [7:0]             frame_bytes [$];
    logic [LENGTH_BITS-1:0] frame_len;

    int   failures    = 0;
    int   cycle_count = 0;
    int   items_sent  = 0;
    logic no_idle     = 1'b0;

    tlv_stream_parser_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .buffer_length (buffer_length),
        .start_req     (start_req),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_res     (event_res),
        .record_type   (record_type),
        .record_length (record_length),
        .payload_byte  (payload_byte),
        .payload_index (payload_index),
        .status        (status),
        .last_of_run   (last_of_run)
    );

    always #5 clk = ~clk;

    task automatic push_event(input logic [1:0] ev, input logic [7:0] typ,
                              input logic [15:0] len, input logic [7:0] pb,
                              input logic [15:0] pi, input logic [2:0] st);
        result_t r;
        r.event_res     = ev;
        r.record_type   = typ;
        r.record_length = len;
        r.payload_byte  = pb;
        r.payload_index = pi;
        r.status        = st;
        r.last_of_run   = 1'b0;
        byte_events.push_back(r);
    endtask

    task automatic push_finish(input logic [2:0] st);
        push_event(EV_FINISH, 8'h00, 16'h0000, 8'h00, 16'h0000, st);
        halted = 1'b1;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic [LENGTH_BITS-1:0] blen,
                              input logic st);
        int         p;
        logic [7:0] magic;
        result_t    tail;
        byte_events.delete();
        if (st)
        begin
            byte_pos  = '0;
            phase     = SEEK_HEADER;
            rec_type  = '0;
            len_hi    = '0;
            rec_len   = '0;
            pay_count = '0;
            buf_len   = blen;
            halted    = 1'b0;
        end
        p = int'(byte_pos);
        if (st && blen < HDR_LEN)
        begin
            push_finish(ST_TOO_SMALL);
        end
        else if (!halted)
        begin
            case (phase)
                SEEK_HEADER:
                begin
                    magic = 8'(MAGIC_WORD >> (8 * (3 - (p & 3))));
                    if (p < MAGIC_LEN)
                    begin
                        if (b != magic)
                            push_finish(ST_BAD_MAGIC);
                    end
                    else if (b != VERSION_BYTE)
                        push_finish(ST_BAD_VERSION);
                    else if (p + 1 >= buf_len)
                        push_finish(ST_OK);
                    else
                        phase = SEEK_TYPE;
                end
                SEEK_TYPE:
                begin
                    if (p + REC_HDR_LEN > buf_len)
                    begin
                        push_finish(ST_TRUNC_HDR);
                    end
                    else
                    begin
                        rec_type = b;
                        phase    = SEEK_LEN_HI;
                    end
                end
                SEEK_LEN_HI:
                begin
                    len_hi = b;
                    phase  = SEEK_LEN_LO;
                end
                SEEK_LEN_LO:
                begin
                    rec_len = {len_hi, b};
                    if (p + 1 + rec_len > buf_len)
                    begin
                        push_finish(ST_OVERRUN);
                    end
                    else
                    begin
                        push_event(EV_HEADER, rec_type, rec_len, 8'h00, 16'h0000, ST_OK);
                        pay_count = '0;
                        if (rec_len != 0)
                            phase = SEEK_PAYLOAD;
                        else if (p + 1 >= buf_len)
                            push_finish(ST_OK);
                        else
                            phase = SEEK_TYPE;
                    end
                end
                default:
                begin
                    push_event(EV_PAYLOAD, rec_type, rec_len, b, pay_count, ST_OK);
                    pay_count = pay_count + 16'd1;
                    if (pay_count >= rec_len)
                    begin
                        if (p + 1 >= buf_len)
                            push_finish(ST_OK);
                        else
                            phase = SEEK_TYPE;
                    end
                end
            endcase
            byte_pos = byte_pos + 1'b1;
        end
        if (byte_events.size() > 0)
        begin
            tail             = byte_events.pop_back();
            tail.last_of_run = 1'b1;
            byte_events.push_back(tail);
        end
    endtask

    task automatic queue_byte_events();
        for (int k = 0; k < byte_events.size(); k++)
            pending_events.push_back(byte_events[k]);
    endtask

    // The request is held, unchanged, until the parser takes it.
    task automatic deliver_byte(input logic [7:0] b, input logic [LENGTH_BITS-1:0] blen,
                                input logic st);
        int gap;
        gap = (!no_idle && $urandom_range(99) < 35) ? $urandom_range(3, 1) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        buffer_length <= blen;
        start_req     <= st;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        parse_byte(b, blen, st);
    endtask

    task automatic feed_byte(input logic [7:0] b, input logic [LENGTH_BITS-1:0] blen,
                             input logic st);
        deliver_byte(b, blen, st);
        queue_byte_events();
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_events.size() != 0)
            @(posedge clk);
    endtask

    // Mostly well-formed buffers; the rest carry a damaged header, a wrong
    // declared length, a missing tail or a length below the header size.
    task automatic build_frame();
        int         nrec;
        int         rlen;
        int         kind;
        int         total;
        int         idx;
        int         keep;
        logic [7:0] flip;
        frame_bytes.delete();
        for (int k = 0; k < MAGIC_LEN; k++)
            frame_bytes.push_back(8'(MAGIC_WORD >> (8 * (3 - k))));
        frame_bytes.push_back(VERSION_BYTE);
        nrec = $urandom_range(4, 0);
        repeat (nrec)
        begin
            rlen = ($urandom_range(9) == 0) ? $urandom_range(40, 6) : $urandom_range(5, 0);
            frame_bytes.push_back(8'($urandom_range(255)));
            frame_bytes.push_back(8'(rlen >> 8));
            frame_bytes.push_back(8'(rlen));
            repeat (rlen)
                frame_bytes.push_back(8'($urandom_range(255)));
        end
        total = frame_bytes.size();
        keep  = total;
        kind  = $urandom_range(99);
        if (kind >= 72 && kind < 78)
        begin
            idx              = $urandom_range(HDR_LEN - 1, 0);
            flip             = 8'($urandom_range(255, 1));
            frame_bytes[idx] = frame_bytes[idx] ^ flip;
        end
        else if (kind >= 78 && kind < 84)
        begin
            total = total - $urandom_range(3, 1);
        end
        else if (kind >= 84 && kind < 88)
        begin
            total = total + $urandom_range(4, 1);
        end
        else if (kind >= 88 && kind < 93)
        begin
            keep = $urandom_range(frame_bytes.size(), 1);
        end
        else if (kind >= 93)
        begin
            total = $urandom_range(HDR_LEN - 1, 1);
            keep  = $urandom_range(HDR_LEN - 1, 1);
        end
        while (frame_bytes.size() > keep)
            void'(frame_bytes.pop_back());
        frame_len = LENGTH_BITS'(total);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            failures++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        out_stall <= !no_idle && ($urandom_range(99) < 35);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_events.size() == 0)
            begin
                failures++;
                $display("%0t: event_res mismatch: expected no event, actual %0h",
                         $time, event_res);
            end
            else
            begin
                head_event = pending_events.pop_front();
                check_field("event_res", 16'(head_event.event_res), 16'(event_res));
                check_field("record_type", 16'(head_event.record_type), 16'(record_type));
                check_field("record_length", head_event.record_length, record_length);
                check_field("payload_byte", 16'(head_event.payload_byte),
                            16'(payload_byte));
                check_field("payload_index", head_event.payload_index, payload_index);
                check_field("status", 16'(head_event.status), 16'(status));
                check_field("last_of_run", 16'(head_event.last_of_run), 16'(last_of_run));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        stim_row_t row;
        result_t   typed;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            row = DIRECTED_ROWS[i];
            deliver_byte(row.data, row.blen, row.start);
            if (row.check == ROW_PREDICT)
            begin
                queue_byte_events();
            end
            else if (row.check == ROW_FINISH)
            begin
                typed             = '0;
                typed.event_res   = EV_FINISH;
                typed.status      = row.status;
                typed.last_of_run = 1'b1;
                pending_events.push_back(typed);
            end
        end
        wait_for_results();

        while (items_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(99) < 7)
            begin
                repeat ($urandom_range(3, 1))
                    feed_byte(8'($urandom_range(255)),
                              LENGTH_BITS'($urandom_range(20'hFFFFF, 1)), 1'b0);
            end
            build_frame();
            for (int k = 0; k < frame_bytes.size(); k++)
            begin
                if (k == 0)
                    feed_byte(frame_bytes[k], frame_len, 1'b1);
                else
                    feed_byte(frame_bytes[k],
                              LENGTH_BITS'($urandom_range(20'hFFFFF, 1)), 1'b0);
                items_sent++;
                no_idle = (items_sent >= 600 && items_sent < 900);
                if (items_sent == 1300)
                    wait_for_results();
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
